FILE: sv/mtct_pkg.sv
`timescale 1ns / 1ps

package mtct_pkg;

	// Configuration register file
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN = 1'd1;
	localparam logic [CFG_W-1:0] RESET_DIM = 7'd64;

	// Item operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Width of the reported row and column positions
	localparam int POS_W = 6;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_DIM    = 64;
	localparam int DEF_DATA_WIDTH = 32;

	// Queue depths
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// Control bits of one command from front to back
	typedef struct packed {
		logic do_read;
		logic do_write;
		logic last;
	} cmd_ctrl_t;

	localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

FILE: sv/mtct_queue.sv
`timescale 1ns / 1ps

module mtct_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rdata = slot_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/mtct_front.sv
`timescale 1ns / 1ps

module mtct_front import mtct_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int IDX_W      = $clog2(MAX_DIM),
	parameter int ADDR_W     = 2 * IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_accept,
	input  logic                  operation,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  cmd_valid,
	output cmd_ctrl_t             cmd_ctrl,
	output logic [ADDR_W-1:0]     cmd_rd_addr,
	output logic [ADDR_W-1:0]     cmd_wr_addr,
	output logic [DATA_WIDTH-1:0] cmd_data,
	output logic [POS_W-1:0]      cmd_row,
	output logic [POS_W-1:0]      cmd_col
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [IDX_W-1:0] wr_row_q;
	logic [IDX_W-1:0] wr_col_q;
	logic [IDX_W-1:0] rd_row_q;
	logic [IDX_W-1:0] rd_col_q;
	logic             wsel_q;
	logic             pending_q;

	logic [CMP_W-1:0] rows_c;
	logic [CMP_W-1:0] cols_c;
	logic [DIM_W-1:0] rows_d;
	logic [DIM_W-1:0] cols_d;
	logic             rd_col_end;
	logic             rd_row_end;
	logic             wr_col_end;
	logic             wr_row_end;
	logic             is_write;
	logic             frame_done;

	// Out-of-range dimensions saturate to 1 and MAX_DIM
	always_comb begin
		rows_c = CMP_W'(rows_q);
		cols_c = CMP_W'(cols_q);
		if (rows_c == '0) begin
			rows_c = CMP_W'(1);
		end else if (rows_c > CMP_W'(MAX_DIM)) begin
			rows_c = CMP_W'(MAX_DIM);
		end
		if (cols_c == '0) begin
			cols_c = CMP_W'(1);
		end else if (cols_c > CMP_W'(MAX_DIM)) begin
			cols_c = CMP_W'(MAX_DIM);
		end
	end

	assign rows_d = DIM_W'(rows_c);
	assign cols_d = DIM_W'(cols_c);

	assign rd_col_end = (DIM_W'(rd_row_q) + DIM_W'(1)) >= cols_d;
	assign rd_row_end = (DIM_W'(rd_col_q) + DIM_W'(1)) >= rows_d;
	assign wr_col_end = (DIM_W'(wr_col_q) + DIM_W'(1)) >= cols_d;
	assign wr_row_end = (DIM_W'(wr_row_q) + DIM_W'(1)) >= rows_d;

	assign is_write   = (operation == OP_WRITE);
	assign frame_done = is_write && wr_col_end && wr_row_end;

	// Drop items that neither read nor write
	assign cmd_valid         = in_accept && (pending_q || is_write);
	assign cmd_ctrl.do_read  = pending_q;
	assign cmd_ctrl.do_write = is_write;
	assign cmd_ctrl.last     = rd_col_end && rd_row_end;
	assign cmd_rd_addr       = {~wsel_q, rd_col_q, rd_row_q};
	assign cmd_wr_addr       = {wsel_q, wr_row_q, wr_col_q};
	assign cmd_data          = value;
	assign cmd_row           = POS_W'(rd_row_q);
	assign cmd_col           = POS_W'(rd_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RESET_DIM;
			cols_q <= RESET_DIM;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_IN: rows_q <= cfg_data;
				REG_COLS_IN: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_row_q  <= '0;
			wr_col_q  <= '0;
			rd_row_q  <= '0;
			rd_col_q  <= '0;
			wsel_q    <= 1'b0;
			pending_q <= 1'b0;
		end else if (in_accept) begin
			if (is_write) begin
				if (wr_col_end) begin
					wr_col_q <= '0;
					if (wr_row_end) begin
						wr_row_q <= '0;
						wsel_q   <= ~wsel_q;
					end else begin
						wr_row_q <= wr_row_q + IDX_W'(1);
					end
				end else begin
					wr_col_q <= wr_col_q + IDX_W'(1);
				end
			end
			// A finished write frame restarts the read side on the new frame
			if (frame_done) begin
				pending_q <= 1'b1;
				rd_row_q  <= '0;
				rd_col_q  <= '0;
			end else if (pending_q) begin
				if (rd_row_end) begin
					rd_col_q <= '0;
					if (rd_col_end) begin
						rd_row_q  <= '0;
						pending_q <= 1'b0;
					end else begin
						rd_row_q <= rd_row_q + IDX_W'(1);
					end
				end else begin
					rd_col_q <= rd_col_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

FILE: sv/mtct_back.sv
`timescale 1ns / 1ps

module mtct_back import mtct_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int IDX_W      = $clog2(MAX_DIM),
	parameter int ADDR_W     = 2 * IDX_W + 1,
	parameter int RES_W      = DATA_WIDTH + 2 * POS_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count,
	input  cmd_ctrl_t                    cmd_ctrl,
	input  logic [ADDR_W-1:0]            cmd_rd_addr,
	input  logic [ADDR_W-1:0]            cmd_wr_addr,
	input  logic [DATA_WIDTH-1:0]        cmd_data,
	input  logic [POS_W-1:0]             cmd_row,
	input  logic [POS_W-1:0]             cmd_col,
	output logic                         cmd_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
	output logic                         res_push,
	output logic [RES_W-1:0]             res_data
);

	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

	// Both banks in one simple dual-port memory; the bank is the top address bit
	logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];

	logic                  valid_s1;
	logic                  last_s1;
	logic [POS_W-1:0]      row_s1;
	logic [POS_W-1:0]      col_s1;
	logic [DATA_WIDTH-1:0] rdata_s1;
	logic                  credit;

	// Hold a read back unless its result has a guaranteed slot
	assign credit  = (res_count + RCNT_W'(valid_s1)) < RCNT_W'(RES_DEPTH);
	assign cmd_pop = (cmd_count != '0) && (!cmd_ctrl.do_read || credit);

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_ctrl.do_write) begin
			mem[cmd_wr_addr] <= cmd_data;
		end
		if (cmd_pop && cmd_ctrl.do_read) begin
			rdata_s1 <= mem[cmd_rd_addr];
			row_s1   <= cmd_row;
			col_s1   <= cmd_col;
			last_s1  <= cmd_ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop && cmd_ctrl.do_read;
		end
	end

	assign res_push = valid_s1;
	assign res_data = {rdata_s1, row_s1, col_s1, last_s1};

endmodule

FILE: sv/matrix_transpose_corner_turn_core.sv
`timescale 1ns / 1ps

// Double-buffered corner turner. Elements of a rows_in x cols_in matrix are
// pushed in row-major order; while one bank fills, the previous frame is read
// out of the other bank in transposed order, one result per pushed item while
// a frame is pending. A drain item (operation = 1) reads without writing so
// the last frame can be flushed. One item is taken every clock while the
// command queue is not full: the front keeps all counters and issues at most
// one command per item, and the back executes each command on one dual-port
// memory (one write port, one read port, registered read), whose read data
// is pushed into the output queue. The memory holds 2 * 2^(2*clog2(MAX_DIM))
// words, has no clearing pass, and is undefined until written. Change rows_in
// and cols_in only while the block is idle.
module matrix_transpose_corner_turn_core import mtct_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic                  operation,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  empty,
	input  logic                  pop,
	output logic [DATA_WIDTH-1:0] elem_value,
	output logic [POS_W-1:0]      out_row,
	output logic [POS_W-1:0]      out_col,
	output logic                  frame_last
);

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = 2 * IDX_W + 1;
	localparam int CMD_W  = CTRL_W + 2 * ADDR_W + DATA_WIDTH + 2 * POS_W;
	localparam int RES_W  = DATA_WIDTH + 2 * POS_W + 1;

	logic                             in_accept;
	logic                             cmd_valid;
	cmd_ctrl_t                        f_ctrl;
	logic [ADDR_W-1:0]                f_rd_addr;
	logic [ADDR_W-1:0]                f_wr_addr;
	logic [DATA_WIDTH-1:0]            f_data;
	logic [POS_W-1:0]                 f_row;
	logic [POS_W-1:0]                 f_col;

	logic [CMD_W-1:0]                 cmd_head;
	logic [$clog2(CMD_DEPTH+1)-1:0]   cmd_count;
	logic                             cmd_pop;
	cmd_ctrl_t                        b_ctrl;
	logic [ADDR_W-1:0]                b_rd_addr;
	logic [ADDR_W-1:0]                b_wr_addr;
	logic [DATA_WIDTH-1:0]            b_data;
	logic [POS_W-1:0]                 b_row;
	logic [POS_W-1:0]                 b_col;

	logic [$clog2(RES_DEPTH+1)-1:0]   res_count;
	logic                             res_push;
	logic [RES_W-1:0]                 res_in;
	logic [RES_W-1:0]                 res_head;
	logic                             res_pop;

	assign cfg_ready = 1'b1;
	assign full      = (cmd_count == ($clog2(CMD_DEPTH+1))'(CMD_DEPTH));
	assign in_accept = push && !full;
	assign empty     = (res_count == '0);
	assign res_pop   = pop && !empty;

	mtct_front #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.IDX_W      (IDX_W),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_accept   (in_accept),
		.operation   (operation),
		.value       (value),
		.cmd_valid   (cmd_valid),
		.cmd_ctrl    (f_ctrl),
		.cmd_rd_addr (f_rd_addr),
		.cmd_wr_addr (f_wr_addr),
		.cmd_data    (f_data),
		.cmd_row     (f_row),
		.cmd_col     (f_col)
	);

	mtct_queue #(
		.W     (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.wdata  ({f_ctrl, f_rd_addr, f_wr_addr, f_data, f_row, f_col}),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.count  (cmd_count)
	);

	assign {b_ctrl, b_rd_addr, b_wr_addr, b_data, b_row, b_col} = cmd_head;

	mtct_back #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.IDX_W      (IDX_W),
		.ADDR_W     (ADDR_W),
		.RES_W      (RES_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_count   (cmd_count),
		.cmd_ctrl    (b_ctrl),
		.cmd_rd_addr (b_rd_addr),
		.cmd_wr_addr (b_wr_addr),
		.cmd_data    (b_data),
		.cmd_row     (b_row),
		.cmd_col     (b_col),
		.cmd_pop     (cmd_pop),
		.res_count   (res_count),
		.res_push    (res_push),
		.res_data    (res_in)
	);

	mtct_queue #(
		.W     (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (res_pop),
		.rdata  (res_head),
		.count  (res_count)
	);

	assign {elem_value, out_row, out_col, frame_last} = res_head;

endmodule
